// File: hdl/pmsb_pkg.sv
package pmsb_pkg;

	localparam int SCREEN_COLUMNS = 128;
	localparam int STORE_BYTES    = 1024;

	localparam int DATA_W = 8;
	localparam int XY_W   = 8;
	localparam int WID_W  = 8;
	localparam int IDX_W  = 10;
	localparam int RA_W   = 10;
	localparam int KIND_W = 2;

	localparam int AW     = $clog2(STORE_BYTES);
	localparam int DVS_W  = WID_W + 1;
	localparam int CNT_W  = $clog2(IDX_W);
	localparam int COL_W  = DVS_W + 1;
	localparam int ROW_W  = IDX_W + 5;
	localparam int PAGE_W = ROW_W - 4;
	localparam int LIN_W  = PAGE_W + $clog2(SCREEN_COLUMNS) + 2;
	localparam int RNG_W  = RA_W + 4;

	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd0;
	localparam logic [KIND_W-1:0] KIND_BLIT  = 2'd1;
	localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

	typedef enum logic [1:0] {
		CMD_CLEAR,
		CMD_BLIT,
		CMD_READ
	} cmd_op_t;

	typedef struct packed {
		cmd_op_t           op;
		logic [AW-1:0]     word_addr;
		logic [RA_W-1:0]   ret_addr;
		logic              in_range;
		logic [DATA_W-1:0] lo;
		logic [DATA_W-1:0] hi;
		logic              dual;
	} cmd_t;

	typedef struct packed {
		logic init_busy;
	} back_stat_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_DIV,
		F_PLACE
	} fstate_t;

	typedef enum logic [2:0] {
		B_SWEEP,
		B_IDLE,
		B_MOD1,
		B_MOD2,
		B_RET
	} bstate_t;

endpackage

// File: hdl/pmsb_if.sv
interface pmsb_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [pmsb_pkg::KIND_W-1:0]          kind;
	logic signed [pmsb_pkg::XY_W-1:0]     origin_x;
	logic signed [pmsb_pkg::XY_W-1:0]     origin_y;
	logic [pmsb_pkg::WID_W-1:0]           sprite_width;
	logic [pmsb_pkg::IDX_W-1:0]           byte_index;
	logic [pmsb_pkg::DATA_W-1:0]          sprite_bits;
	logic [pmsb_pkg::RA_W-1:0]            read_address;

	modport source (
		output valid, kind, origin_x, origin_y, sprite_width, byte_index, sprite_bits,
			read_address,
		input  ready
	);
	modport sink (
		input  valid, kind, origin_x, origin_y, sprite_width, byte_index, sprite_bits,
			read_address,
		output ready
	);
endinterface

interface pmsb_out_if;
	logic                          valid;
	logic                          ready;
	logic [pmsb_pkg::RA_W-1:0]     byte_address;
	logic [pmsb_pkg::DATA_W-1:0]   byte_value;

	modport source (output valid, byte_address, byte_value, input ready);
	modport sink (input valid, byte_address, byte_value, output ready);
endinterface

// File: hdl/pmsb_front.sv
module pmsb_front (
	input  logic                 clk,
	input  logic                 arst_n,
	pmsb_in_if.sink              item,
	output pmsb_pkg::cmd_t       cmd,
	output logic                 cmd_valid,
	input  logic                 cmd_ready,
	input  pmsb_pkg::back_stat_t stat
);

	pmsb_pkg::fstate_t st_q, st_d;

	logic                                cmd_vld_q;
	pmsb_pkg::cmd_t                      cmd_q;
	logic [pmsb_pkg::IDX_W-1:0]          dvd_q;
	logic [pmsb_pkg::DVS_W-1:0]          rem_q;
	logic [pmsb_pkg::DVS_W-1:0]          dvs_q;
	logic [pmsb_pkg::CNT_W-1:0]          cnt_q;
	logic signed [pmsb_pkg::XY_W-1:0]    ox_q;
	logic signed [pmsb_pkg::XY_W-1:0]    oy_q;
	logic [pmsb_pkg::DATA_W-1:0]         data_q;

	logic accept;
	logic load_div;
	logic step_div;
	logic place;
	logic direct;

	logic [pmsb_pkg::DVS_W:0]            trial;
	logic                                trial_ge;
	logic [pmsb_pkg::DVS_W-1:0]          rem_nx;

	logic signed [pmsb_pkg::COL_W-1:0]   col_c;
	logic signed [pmsb_pkg::COL_W-1:0]   col_adj;
	logic signed [pmsb_pkg::ROW_W-1:0]   row_c;
	logic [pmsb_pkg::PAGE_W-1:0]         page;
	logic [pmsb_pkg::LIN_W-1:0]          lin;
	logic [2:0]                          shift;
	logic [2*pmsb_pkg::DATA_W-1:0]       wide;
	logic                                drop;
	pmsb_pkg::cmd_t                      place_cmd;
	pmsb_pkg::cmd_t                      direct_cmd;

	assign item.ready = (st_q == pmsb_pkg::F_IDLE) && !cmd_vld_q && !stat.init_busy;
	assign accept     = item.valid && item.ready;
	assign cmd        = cmd_q;
	assign cmd_valid  = cmd_vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pmsb_pkg::F_IDLE;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		load_div = 1'b0;
		step_div = 1'b0;
		place    = 1'b0;
		direct   = 1'b0;
		case (st_q)
			pmsb_pkg::F_IDLE: begin
				if (accept) begin
					if (item.kind == pmsb_pkg::KIND_BLIT) begin
						load_div = 1'b1;
						st_d     = pmsb_pkg::F_DIV;
					end else if (item.kind inside {pmsb_pkg::KIND_CLEAR,
						pmsb_pkg::KIND_READ}) begin
						direct = 1'b1;
					end
				end
			end
			pmsb_pkg::F_DIV: begin
				step_div = 1'b1;
				if (cnt_q == pmsb_pkg::CNT_W'(pmsb_pkg::IDX_W - 1)) begin
					st_d = pmsb_pkg::F_PLACE;
				end
			end
			pmsb_pkg::F_PLACE: begin
				place = 1'b1;
				st_d  = pmsb_pkg::F_IDLE;
			end
			default: begin
				st_d = pmsb_pkg::F_IDLE;
			end
		endcase
	end

	// restoring division, one quotient bit a cycle
	assign trial    = {rem_q, dvd_q[pmsb_pkg::IDX_W-1]};
	assign trial_ge = trial >= {1'b0, dvs_q};
	assign rem_nx   = trial_ge ? pmsb_pkg::DVS_W'(trial - {1'b0, dvs_q})
		: pmsb_pkg::DVS_W'(trial);

	assign col_c   = pmsb_pkg::COL_W'(ox_q) + $signed({1'b0, rem_q});
	assign col_adj = col_c[pmsb_pkg::COL_W-1]
		? col_c + pmsb_pkg::COL_W'(pmsb_pkg::SCREEN_COLUMNS) : col_c;
	assign row_c   = pmsb_pkg::ROW_W'(oy_q)
		+ $signed({{(pmsb_pkg::ROW_W - pmsb_pkg::IDX_W - 3){1'b0}}, dvd_q, 3'b000});
	assign page    = row_c[pmsb_pkg::ROW_W-2:3];
	assign shift   = row_c[2:0];
	assign lin     = pmsb_pkg::LIN_W'(page) * pmsb_pkg::LIN_W'(pmsb_pkg::SCREEN_COLUMNS)
		+ pmsb_pkg::LIN_W'(col_adj[pmsb_pkg::COL_W-2:0]);
	assign wide    = {{pmsb_pkg::DATA_W{1'b0}}, data_q} << shift;
	assign drop    = col_adj[pmsb_pkg::COL_W-1] || row_c[pmsb_pkg::ROW_W-1]
		|| (lin >= pmsb_pkg::LIN_W'(pmsb_pkg::STORE_BYTES));

	always_comb begin
		place_cmd           = '0;
		place_cmd.op        = pmsb_pkg::CMD_BLIT;
		place_cmd.word_addr = pmsb_pkg::AW'(lin);
		place_cmd.lo        = wide[pmsb_pkg::DATA_W-1:0];
		place_cmd.hi        = wide[2*pmsb_pkg::DATA_W-1:pmsb_pkg::DATA_W];
		place_cmd.dual      = (shift != 3'd0) && (lin + pmsb_pkg::LIN_W'(pmsb_pkg::SCREEN_COLUMNS)
			< pmsb_pkg::LIN_W'(pmsb_pkg::STORE_BYTES));
	end

	always_comb begin
		direct_cmd           = '0;
		direct_cmd.op        = (item.kind == pmsb_pkg::KIND_READ)
			? pmsb_pkg::CMD_READ : pmsb_pkg::CMD_CLEAR;
		direct_cmd.word_addr = pmsb_pkg::AW'(item.read_address);
		direct_cmd.ret_addr  = item.read_address;
		direct_cmd.in_range  = pmsb_pkg::RNG_W'(item.read_address)
			< pmsb_pkg::RNG_W'(pmsb_pkg::STORE_BYTES);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_vld_q <= 1'b0;
		end else if (direct || (place && !drop)) begin
			cmd_vld_q <= 1'b1;
		end else if (cmd_ready) begin
			cmd_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (load_div) begin
			cnt_q <= '0;
		end else if (step_div) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (direct) begin
			cmd_q <= direct_cmd;
		end else if (place) begin
			cmd_q <= place_cmd;
		end
		if (load_div) begin
			dvd_q  <= item.byte_index;
			rem_q  <= '0;
			dvs_q  <= (item.sprite_width == '0) ? pmsb_pkg::DVS_W'(1) << pmsb_pkg::WID_W
				: pmsb_pkg::DVS_W'(item.sprite_width);
			ox_q   <= item.origin_x;
			oy_q   <= item.origin_y;
			data_q <= item.sprite_bits;
		end else if (step_div) begin
			dvd_q <= {dvd_q[pmsb_pkg::IDX_W-2:0], trial_ge};
			rem_q <= rem_nx;
		end
	end

endmodule

// File: hdl/pmsb_queue.sv
module pmsb_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  pmsb_pkg::cmd_t push_cmd,
	input  logic           push_valid,
	output logic           push_ready,
	output pmsb_pkg::cmd_t pop_cmd,
	output logic           pop_valid,
	input  logic           pop_ready
);

	pmsb_pkg::cmd_t                ent_q [pmsb_pkg::QDEPTH];
	logic [pmsb_pkg::QPTR_W-1:0]   head_q;
	logic [pmsb_pkg::QPTR_W-1:0]   tail_q;
	logic [pmsb_pkg::QCNT_W-1:0]   count_q;
	logic                          do_push;
	logic                          do_pop;

	assign push_ready = count_q != pmsb_pkg::QCNT_W'(pmsb_pkg::QDEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_cmd    = ent_q[head_q];
	assign do_push    = push_valid && push_ready;
	assign do_pop     = pop_valid && pop_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (do_push) begin
				tail_q <= tail_q + 1'b1;
			end
			if (do_pop) begin
				head_q <= head_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			ent_q[tail_q] <= push_cmd;
		end
	end

endmodule

// File: hdl/pmsb_back.sv
module pmsb_back (
	input  logic                 clk,
	input  logic                 arst_n,
	input  pmsb_pkg::cmd_t       cmd,
	input  logic                 cmd_valid,
	output logic                 cmd_ready,
	pmsb_out_if.source           result,
	output pmsb_pkg::back_stat_t stat
);

	pmsb_pkg::bstate_t st_q, st_d;

	logic [pmsb_pkg::DATA_W-1:0]   store_q [pmsb_pkg::STORE_BYTES];
	logic [pmsb_pkg::DATA_W-1:0]   rdata_q;
	logic [pmsb_pkg::AW-1:0]       sweep_q;
	logic                          init_q;
	pmsb_pkg::cmd_t                cur_q;
	logic                          res_vld_q;
	logic [pmsb_pkg::RA_W-1:0]     res_addr_q;
	logic [pmsb_pkg::DATA_W-1:0]   res_val_q;

	logic                          pop;
	logic                          rd_en;
	logic [pmsb_pkg::AW-1:0]       rd_addr;
	logic                          we;
	logic [pmsb_pkg::AW-1:0]       wa;
	logic [pmsb_pkg::DATA_W-1:0]   wd;
	logic                          res_load;
	logic                          sweep_last;
	logic [pmsb_pkg::AW-1:0]       addr2;

	assign sweep_last     = sweep_q == pmsb_pkg::AW'(pmsb_pkg::STORE_BYTES - 1);
	assign addr2          = cur_q.word_addr + pmsb_pkg::AW'(pmsb_pkg::SCREEN_COLUMNS);
	assign cmd_ready      = pop;
	assign stat.init_busy = init_q;

	assign result.valid        = res_vld_q;
	assign result.byte_address = res_addr_q;
	assign result.byte_value   = res_val_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= pmsb_pkg::B_SWEEP;
		end else begin
			st_q <= st_d;
		end
	end

	always_comb begin
		st_d     = st_q;
		pop      = 1'b0;
		rd_en    = 1'b0;
		rd_addr  = '0;
		we       = 1'b0;
		wa       = '0;
		wd       = '0;
		res_load = 1'b0;
		case (st_q)
			pmsb_pkg::B_SWEEP: begin
				we = 1'b1;
				wa = sweep_q;
				if (sweep_last) begin
					st_d = pmsb_pkg::B_IDLE;
				end
			end
			pmsb_pkg::B_IDLE: begin
				if (cmd_valid && (cmd.op != pmsb_pkg::CMD_READ || !res_vld_q)) begin
					pop = 1'b1;
					case (cmd.op)
						pmsb_pkg::CMD_CLEAR: begin
							st_d = pmsb_pkg::B_SWEEP;
						end
						pmsb_pkg::CMD_BLIT: begin
							rd_en   = 1'b1;
							rd_addr = cmd.word_addr;
							st_d    = pmsb_pkg::B_MOD1;
						end
						pmsb_pkg::CMD_READ: begin
							rd_en   = cmd.in_range;
							rd_addr = cmd.word_addr;
							st_d    = pmsb_pkg::B_RET;
						end
						default: begin
							st_d = pmsb_pkg::B_IDLE;
						end
					endcase
				end
			end
			pmsb_pkg::B_MOD1: begin
				we = 1'b1;
				wa = cur_q.word_addr;
				wd = rdata_q | cur_q.lo;
				if (cur_q.dual) begin
					rd_en   = 1'b1;
					rd_addr = addr2;
					st_d    = pmsb_pkg::B_MOD2;
				end else begin
					st_d = pmsb_pkg::B_IDLE;
				end
			end
			pmsb_pkg::B_MOD2: begin
				we   = 1'b1;
				wa   = addr2;
				wd   = rdata_q | cur_q.hi;
				st_d = pmsb_pkg::B_IDLE;
			end
			pmsb_pkg::B_RET: begin
				res_load = 1'b1;
				st_d     = pmsb_pkg::B_IDLE;
			end
			default: begin
				st_d = pmsb_pkg::B_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sweep_q   <= '0;
			init_q    <= 1'b1;
			res_vld_q <= 1'b0;
		end else begin
			if (st_q == pmsb_pkg::B_SWEEP) begin
				sweep_q <= sweep_last ? '0 : sweep_q + 1'b1;
				if (sweep_last) begin
					init_q <= 1'b0;
				end
			end
			if (res_load) begin
				res_vld_q <= 1'b1;
			end else if (result.ready) begin
				res_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= cmd;
		end
		if (res_load) begin
			res_addr_q <= cur_q.ret_addr;
			res_val_q  <= cur_q.in_range ? rdata_q : '0;
		end
	end

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[wa] <= wd;
		end
		if (rd_en) begin
			rdata_q <= store_q[rd_addr];
		end
	end

endmodule

// File: hdl/page_mode_sprite_blitter_top.sv
// Read word: front end register, command queue, frame store read, then the result register.
// Blit word: bit-serial index division in the front end, then placement,
// then a read-modify-write of one or two frame store bytes in the back end.
// Clear word: one frame store byte a cycle in the back end, all 1024 bytes zeroed.
// Reset: asynchronous, active low; afterwards a zeroing sweep of all 1024 frame store bytes
// runs and no word is accepted until it ends.
module page_mode_sprite_blitter_top (
	input  logic        clk,
	input  logic        arst_n,
	pmsb_in_if.sink     item,
	pmsb_out_if.source  result
);

	pmsb_pkg::cmd_t       f_cmd;
	logic                 f_valid;
	logic                 f_ready;
	pmsb_pkg::cmd_t       q_cmd;
	logic                 q_valid;
	logic                 q_ready;
	pmsb_pkg::back_stat_t stat;

	pmsb_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cmd       (f_cmd),
		.cmd_valid (f_valid),
		.cmd_ready (f_ready),
		.stat      (stat)
	);

	pmsb_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_cmd   (f_cmd),
		.push_valid (f_valid),
		.push_ready (f_ready),
		.pop_cmd    (q_cmd),
		.pop_valid  (q_valid),
		.pop_ready  (q_ready)
	);

	pmsb_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (q_cmd),
		.cmd_valid (q_valid),
		.cmd_ready (q_ready),
		.result    (result),
		.stat      (stat)
	);

endmodule

// File: hdl/pmsb_checker.sv
module pmsb_checker (
	input logic                              clk,
	input logic                              arst_n,
	input logic                              item_valid,
	input logic                              item_ready,
	input logic [pmsb_pkg::KIND_W-1:0]       item_kind,
	input logic                              res_valid,
	input logic                              res_ready,
	input logic [pmsb_pkg::RA_W-1:0]         res_addr,
	input logic [pmsb_pkg::DATA_W-1:0]       res_value
);

	logic [3:0] pending_q;
	logic       rd_in;
	logic       rd_out;

	assign rd_in  = item_valid && item_ready && (item_kind == pmsb_pkg::KIND_READ);
	assign rd_out = res_valid && res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pending_q <= '0;
		end else if (rd_in && !rd_out) begin
			pending_q <= pending_q + 1'b1;
		end else if (rd_out && !rd_in) begin
			pending_q <= pending_q - 1'b1;
		end
	end

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid)
		else $error("result word dropped while stalled");

	a_res_stable: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> $stable(res_addr) && $stable(res_value))
		else $error("result word changed while stalled");

	a_res_owed: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> pending_q != '0)
		else $error("result word without a pending read");

	a_blit_busy: assert property (@(posedge clk) disable iff (!arst_n)
		item_valid && item_ready && item_kind == pmsb_pkg::KIND_BLIT |=> !item_ready)
		else $error("blit word accepted without front end going busy");

endmodule

bind page_mode_sprite_blitter_top pmsb_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.item_valid (item.valid),
	.item_ready (item.ready),
	.item_kind  (item.kind),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_addr   (result.byte_address),
	.res_value  (result.byte_value)
);
